/* rtl/mlr_pkg.sv */
// shared types and constants for the midpoint line rasterizer
// no dependencies; used by every module in rtl/
package mlr_pkg;

	localparam int COORD_BITS  = 11;
	localparam int DEC_BITS    = COORD_BITS + 3;
	localparam int COLOR_BITS  = 8;
	localparam logic [COLOR_BITS-1:0] COLOR_RESET = COLOR_BITS'(3);

	// command queue between front and back end, depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	// classified command handed from front end to back end
	typedef struct packed {
		logic   kind;
		coord_t start_x;
		coord_t start_y;
		coord_t major_end;
		logic   steep;
		logic   minor_down;
		logic   single;       // endpoints coincide along the major axis
		dec_t   dec_init;     // 2*dminor - dmajor
		dec_t   inc_straight; // 2*dminor
		dec_t   inc_diag;     // 2*(dminor - dmajor)
	} mlr_cmd_t;

	// queue status seen by its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} mlr_qstat_t;

endpackage

/* rtl/mlr_front.sv */
// front end: accepts input transactions, takes deltas and orders endpoints
// depends on mlr_pkg
module mlr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  mlr_pkg::coord_t       x_start,
	input  mlr_pkg::coord_t       y_start,
	input  mlr_pkg::coord_t       x_end,
	input  mlr_pkg::coord_t       y_end,
	input  mlr_pkg::mlr_qstat_t   qstat,
	output logic                  push,
	output mlr_pkg::mlr_cmd_t     push_cmd
);

	logic            valid_s1;
	logic            kind_s1;
	mlr_pkg::coord_t xa_s1, ya_s1, xb_s1, yb_s1;
	mlr_pkg::coord_t dx_s1, dy_s1;
	logic            x_gt_s1, x_lt_s1, y_gt_s1, y_lt_s1;

	logic            x_gt, x_lt, y_gt, y_lt;
	logic            steep, swap;
	mlr_pkg::coord_t dmaj, dmin;
	mlr_pkg::dec_t   dmaj_w, dmin_w;

	assign x_gt = x_start > x_end;
	assign x_lt = x_start < x_end;
	assign y_gt = y_start > y_end;
	assign y_lt = y_start < y_end;

	assign push     = valid_s1 && !qstat.full;
	assign in_ready = !valid_s1 || !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			xa_s1   <= x_start;
			ya_s1   <= y_start;
			xb_s1   <= x_end;
			yb_s1   <= y_end;
			dx_s1   <= x_gt ? (x_start - x_end) : (x_end - x_start);
			dy_s1   <= y_gt ? (y_start - y_end) : (y_end - y_start);
			x_gt_s1 <= x_gt;
			x_lt_s1 <= x_lt;
			y_gt_s1 <= y_gt;
			y_lt_s1 <= y_lt;
		end
	end

	// ordering along the major axis; ties keep the first endpoint as start
	assign steep  = dy_s1 >= dx_s1;
	assign swap   = steep ? y_gt_s1 : x_gt_s1;
	assign dmaj   = steep ? dy_s1 : dx_s1;
	assign dmin   = steep ? dx_s1 : dy_s1;
	assign dmaj_w = mlr_pkg::dec_t'({2'b00, dmaj});
	assign dmin_w = mlr_pkg::dec_t'({2'b00, dmin});

	always_comb begin
		push_cmd              = '0;
		push_cmd.kind         = kind_s1;
		push_cmd.start_x      = swap ? xb_s1 : xa_s1;
		push_cmd.start_y      = swap ? yb_s1 : ya_s1;
		if (steep) begin
			push_cmd.major_end  = swap ? ya_s1 : yb_s1;
			push_cmd.minor_down = swap ? x_lt_s1 : x_gt_s1;
		end else begin
			push_cmd.major_end  = swap ? xa_s1 : xb_s1;
			push_cmd.minor_down = swap ? y_lt_s1 : y_gt_s1;
		end
		push_cmd.steep        = steep;
		push_cmd.single       = (dmaj == '0);
		push_cmd.dec_init     = (dmin_w <<< 1) - dmaj_w;
		push_cmd.inc_straight = dmin_w <<< 1;
		push_cmd.inc_diag     = (dmin_w - dmaj_w) <<< 1;
	end

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && qstat.full)
		else $error("front stalled without a held item");

endmodule

/* rtl/mlr_queue.sv */
// short command queue decoupling front end from back end
// depends on mlr_pkg
module mlr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mlr_pkg::mlr_cmd_t   push_cmd,
	input  logic                pop,
	output mlr_pkg::mlr_cmd_t   head_cmd,
	output mlr_pkg::mlr_qstat_t qstat
);

	mlr_pkg::mlr_cmd_t               entry_q [mlr_pkg::QUEUE_DEPTH];
	logic [mlr_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [mlr_pkg::QCNT_BITS-1:0]   count_q;

	assign qstat.full  = (count_q == mlr_pkg::QCNT_BITS'(mlr_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

/* rtl/mlr_back.sv */
// back end: line stepping state, decision update and output register
// depends on mlr_pkg
module mlr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mlr_pkg::mlr_qstat_t                 qstat,
	input  mlr_pkg::mlr_cmd_t                   head_cmd,
	output logic                                pop,
	input  logic [mlr_pkg::COLOR_BITS-1:0]      color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mlr_pkg::coord_t                     pixel_x,
	output mlr_pkg::coord_t                     pixel_y,
	output logic                                pixel_valid,
	output logic                                last_pixel,
	output logic [mlr_pkg::COLOR_BITS-1:0]      color_out
);

	mlr_pkg::coord_t cur_x_q, cur_y_q, major_end_q;
	mlr_pkg::dec_t   decision_q, inc_straight_q, inc_diag_q;
	logic            steep_q, minor_down_q, active_q;
	logic            out_valid_q;

	logic            minor_step, done;
	mlr_pkg::coord_t maj, mino, maj_next, mino_next, nx, ny;
	mlr_pkg::dec_t   dec_next;

	assign pop       = !qstat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign minor_step = !decision_q[mlr_pkg::DEC_BITS-1];
	assign maj        = steep_q ? cur_y_q : cur_x_q;
	assign mino       = steep_q ? cur_x_q : cur_y_q;
	assign maj_next   = maj + 1'b1;
	assign mino_next  = !minor_step ? mino : (minor_down_q ? mino - 1'b1 : mino + 1'b1);
	assign dec_next   = decision_q + (minor_step ? inc_diag_q : inc_straight_q);
	assign done       = (maj_next == major_end_q);
	assign nx         = steep_q ? mino_next : maj_next;
	assign ny         = steep_q ? maj_next : mino_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			active_q       <= 1'b0;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			major_end_q    <= '0;
			decision_q     <= '0;
			inc_straight_q <= '0;
			inc_diag_q     <= '0;
			steep_q        <= 1'b0;
			minor_down_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
				if (head_cmd.kind == mlr_pkg::KIND_LOAD) begin
					cur_x_q        <= head_cmd.start_x;
					cur_y_q        <= head_cmd.start_y;
					major_end_q    <= head_cmd.major_end;
					decision_q     <= head_cmd.dec_init;
					inc_straight_q <= head_cmd.inc_straight;
					inc_diag_q     <= head_cmd.inc_diag;
					steep_q        <= head_cmd.steep;
					minor_down_q   <= head_cmd.minor_down;
					active_q       <= !head_cmd.single;
				end else if (active_q) begin
					cur_x_q    <= nx;
					cur_y_q    <= ny;
					decision_q <= dec_next;
					active_q   <= !done;
				end
			end
		end
	end

	// result payload, loaded with the state update
	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_cmd.kind == mlr_pkg::KIND_LOAD) begin
				pixel_x     <= head_cmd.start_x;
				pixel_y     <= head_cmd.start_y;
				pixel_valid <= 1'b1;
				last_pixel  <= head_cmd.single;
				color_out   <= color;
			end else if (active_q) begin
				pixel_x     <= nx;
				pixel_y     <= ny;
				pixel_valid <= 1'b1;
				last_pixel  <= done;
				color_out   <= color;
			end else begin
				pixel_x     <= '0;
				pixel_y     <= '0;
				pixel_valid <= 1'b0;
				last_pixel  <= 1'b0;
				color_out   <= '0;
			end
		end
	end

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pixel_valid && last_pixel |-> !active_q)
		else $error("line still active after its last pixel");

	a_more_keeps_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pixel_valid && !last_pixel |-> active_q)
		else $error("line idle before its last pixel");

endmodule

/* rtl/midpoint_line_rasterizer.sv */
// top level of the midpoint line rasterizer
// depends on mlr_pkg, mlr_front, mlr_queue, mlr_back

// Midpoint line rasterizer, pull style: a load transaction (kind 0) carries
// two endpoints and returns the first pixel of the line; every advance
// transaction (kind 1) returns the next pixel, last_pixel marks the final
// one, and an advance with no line in progress returns pixel_valid 0 with
// all other fields 0. Each input transaction gives exactly one output
// transaction, in order. Throughput is one transaction per clock on both
// sides while out_ready stays high; the back end does its decision update
// (one 14-bit add) and coordinate step for each pixel as it pops a command.
// From input acceptance to out_valid an item passes the front end register,
// the two-entry command queue and the output register, in that order.
// The queue lets the front end keep taking input while the output is
// stalled, until the queue fills. pixel_color is written on the cfg
// channel (always ready) and is sampled when each pixel is produced.
module midpoint_line_rasterizer (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  mlr_pkg::coord_t                   x_start,
	input  mlr_pkg::coord_t                   y_start,
	input  mlr_pkg::coord_t                   x_end,
	input  mlr_pkg::coord_t                   y_end,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output mlr_pkg::coord_t                   pixel_x,
	output mlr_pkg::coord_t                   pixel_y,
	output logic                              pixel_valid,
	output logic                              last_pixel,
	output logic [mlr_pkg::COLOR_BITS-1:0]    color_out,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mlr_pkg::COLOR_BITS-1:0]    cfg_data
);

	logic [mlr_pkg::COLOR_BITS-1:0] pixel_color_q;
	logic                           push, pop;
	mlr_pkg::mlr_cmd_t              push_cmd, head_cmd;
	mlr_pkg::mlr_qstat_t            qstat;

	// configuration write is a single register, never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_color_q <= mlr_pkg::COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pixel_color_q <= cfg_data;
		end
	end

	// front end: register the transaction, take deltas, classify and order
	mlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// command queue between the two halves
	mlr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.qstat    (qstat)
	);

	// back end: line state, one pixel step per popped command
	mlr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.color       (pixel_color_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_valid (pixel_valid),
		.last_pixel  (last_pixel),
		.color_out   (color_out)
	);

endmodule

/* tb/midpoint_line_rasterizer_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for midpoint_line_rasterizer: directed table, then random line traffic
// depends on rtl/mlr_pkg.sv and rtl/midpoint_line_rasterizer.sv
module midpoint_line_rasterizer_tb;

	// front register, command queue and output register
	localparam int PIPE_LATENCY = 3;
	// cycles with no transaction on any channel before the run is called hung
	localparam int QUIET_LIMIT  = 2000;
	// random items per color setting, sent in two halves with a full drain between
	localparam int PHASE_ITEMS  = 250;
	localparam int COORD_TOP    = (1 << mlr_pkg::COORD_BITS) - 1;
	// keep the log readable if the design is badly broken
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		logic            kind;
		mlr_pkg::coord_t x_start;
		mlr_pkg::coord_t y_start;
		mlr_pkg::coord_t x_end;
		mlr_pkg::coord_t y_end;
	} line_cmd_t;

	typedef struct packed {
		mlr_pkg::coord_t                px;
		mlr_pkg::coord_t                py;
		logic                           valid;
		logic                           last;
		logic [mlr_pkg::COLOR_BITS-1:0] color;
	} pixel_t;

	typedef struct packed {
		line_cmd_t cmd;
		logic      typed;
		pixel_t    want;
	} dir_row_t;

	// receiver stall patterns
	typedef enum int {SINK_FREE, SINK_RANDOM, SINK_QUARTER, SINK_EIGHTH} sink_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           kind = mlr_pkg::KIND_LOAD;
	mlr_pkg::coord_t                x_start = '0;
	mlr_pkg::coord_t                y_start = '0;
	mlr_pkg::coord_t                x_end = '0;
	mlr_pkg::coord_t                y_end = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	mlr_pkg::coord_t                pixel_x;
	mlr_pkg::coord_t                pixel_y;
	logic                           pixel_valid;
	logic                           last_pixel;
	logic [mlr_pkg::COLOR_BITS-1:0] color_out;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [mlr_pkg::COLOR_BITS-1:0] cfg_data = '0;

	midpoint_line_rasterizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_valid(pixel_valid),
		.last_pixel (last_pixel),
		.color_out  (color_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// line tracer: our own copy of the rasterizer state, reset values
	// ------------------------------------------------------------------
	mlr_pkg::coord_t                trace_x = '0;
	mlr_pkg::coord_t                trace_y = '0;
	mlr_pkg::coord_t                trace_end = '0;    // major coordinate of the final pixel
	mlr_pkg::coord_t                span_major = '0;
	mlr_pkg::coord_t                span_minor = '0;
	mlr_pkg::dec_t                  err_term = '0;     // doubled midpoint error
	logic                           trace_steep = 1'b0;
	logic                           trace_down = 1'b0;
	logic                           tracing = 1'b0;    // pixels remain after the current one
	logic [mlr_pkg::COLOR_BITS-1:0] color_reg = mlr_pkg::COLOR_RESET;

	pixel_t      pending_pixels[$];
	dir_row_t    directed_rows[$];
	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	int          burst_left = 0;

	// works out the pixel that one accepted transaction returns and steps the tracer
	task automatic trace_pixel(input line_cmd_t c, output pixel_t p);
		mlr_pkg::coord_t xa, ya, xb, yb, dx, dy, t;
		logic            swap;
		if (c.kind == mlr_pkg::KIND_LOAD) begin
			xa = c.x_start;
			ya = c.y_start;
			xb = c.x_end;
			yb = c.y_end;
			// absolute deltas first, then pick the major axis
			dx = (xa > xb) ? xa - xb : xb - xa;
			dy = (ya > yb) ? ya - yb : yb - ya;
			// equal deltas count as steep
			trace_steep = (dy >= dx);
			// order so the major coordinate rises; a tie keeps the first endpoint
			swap = trace_steep ? (ya > yb) : (xa > xb);
			if (swap) begin
				t = xa; xa = xb; xb = t;
				t = ya; ya = yb; yb = t;
			end
			trace_x = xa;
			trace_y = ya;
			if (trace_steep) begin
				span_major = dy;
				span_minor = dx;
				trace_end  = yb;
				trace_down = (xb < xa);
			end else begin
				span_major = dx;
				span_minor = dy;
				trace_end  = xb;
				trace_down = (yb < ya);
			end
			err_term = mlr_pkg::dec_t'(2 * int'(span_minor) - int'(span_major));
			// a single point line is done on its load
			tracing = (span_major != '0);
			p = '{trace_x, trace_y, 1'b1, !tracing, color_reg};
		end else if (!tracing) begin
			// advance with no line in progress: everything zero
			p = '0;
		end else begin
			if (err_term >= 0) begin
				if (trace_steep)
					trace_x = trace_down ? trace_x - 1'b1 : trace_x + 1'b1;
				else
					trace_y = trace_down ? trace_y - 1'b1 : trace_y + 1'b1;
				err_term = mlr_pkg::dec_t'(int'(err_term)
					+ 2 * (int'(span_minor) - int'(span_major)));
			end else begin
				err_term = mlr_pkg::dec_t'(int'(err_term) + 2 * int'(span_minor));
			end
			if (trace_steep) begin
				trace_y = trace_y + 1'b1;
				if (trace_y == trace_end)
					tracing = 1'b0;
			end else begin
				trace_x = trace_x + 1'b1;
				if (trace_x == trace_end)
					tracing = 1'b0;
			end
			p = '{trace_x, trace_y, 1'b1, !tracing, color_reg};
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned want, input int unsigned got);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t: %s, expected %0d, got %0d", $time, what, want, got);
	endtask

	// ------------------------------------------------------------------
	// output side: stall pattern and scoreboard
	// ------------------------------------------------------------------
	sink_mode_t sink_mode = SINK_FREE;
	int         mode_left = 0;
	logic [2:0] sink_tick = '0;

	// each pattern holds for a random stretch; the free one gives runs with no stalls
	always @(posedge clk) begin
		sink_tick <= sink_tick + 1'b1;
		if (mode_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(16, 160);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (sink_mode)
			SINK_FREE:    out_ready <= 1'b1;
			SINK_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
			SINK_QUARTER: out_ready <= (sink_tick[1:0] == 2'd0);
			default:      out_ready <= (sink_tick == 3'd7);
		endcase
	end

	// every output transaction is matched against the oldest expected pixel
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with nothing expected, pixel_valid", 0,
					32'(pixel_valid));
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_x !== want.px)
					report_mismatch("pixel_x", 32'(want.px), 32'(pixel_x));
				if (pixel_y !== want.py)
					report_mismatch("pixel_y", 32'(want.py), 32'(pixel_y));
				if (pixel_valid !== want.valid)
					report_mismatch("pixel_valid", 32'(want.valid), 32'(pixel_valid));
				if (last_pixel !== want.last)
					report_mismatch("last_pixel", 32'(want.last), 32'(last_pixel));
				if (color_out !== want.color)
					report_mismatch("color_out", 32'(want.color), 32'(color_out));
			end
		end
	end

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	// sends one transaction in bursts with random gaps; valid stays up between
	// back-to-back items, and the expectation is queued at the accepting edge
	task automatic issue(input line_cmd_t c, input logic typed, input pixel_t want);
		int     gap;
		pixel_t p;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind     <= c.kind;
		x_start  <= c.x_start;
		y_start  <= c.y_start;
		x_end    <= c.x_end;
		y_end    <= c.y_end;
		do @(posedge clk); while (!in_ready);
		trace_pixel(c, p);
		// hand-typed rows override the tracer's answer
		pending_pixels.push_back(typed ? want : p);
		items_sent++;
	endtask

	// sender holds off until every expected pixel has come back
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		burst_left = 0;
	endtask

	// register write, only ever called on a drained block
	task automatic write_color(input logic [mlr_pkg::COLOR_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		color_reg = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic line_cmd_t scrambled(input logic k);
		line_cmd_t c;
		c.kind    = k;
		c.x_start = mlr_pkg::coord_t'($urandom);
		c.y_start = mlr_pkg::coord_t'($urandom);
		c.x_end   = mlr_pkg::coord_t'($urandom);
		c.y_end   = mlr_pkg::coord_t'($urandom);
		return c;
	endfunction

	function automatic int pick_start();
		int r;
		r = $urandom_range(0, 19);
		// now and then sit right on the edge of the coordinate range
		if (r == 0)
			return 0;
		if (r == 1)
			return COORD_TOP;
		return $urandom_range(0, COORD_TOP);
	endfunction

	// one random line: mostly a load followed by its advances, sometimes cut
	// short or run past the end, plus stray advances and abandoned long lines
	task automatic random_sequence();
		line_cmd_t c;
		pixel_t    none;
		int        roll, span, minor, dx, dy, xs, ys, xe, ye, steps;
		none = '0;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			issue(scrambled(mlr_pkg::KIND_ADVANCE), 1'b0, none);
		end else if (roll < 16) begin
			// long line with arbitrary endpoints, dropped by the next load
			issue(scrambled(mlr_pkg::KIND_LOAD), 1'b0, none);
			repeat ($urandom_range(0, 6)) issue(scrambled(mlr_pkg::KIND_ADVANCE), 1'b0, none);
		end else begin
			span  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 90) : $urandom_range(0, 12);
			minor = $urandom_range(0, span);
			if ($urandom_range(0, 1) != 0) begin
				dx = span;
				dy = minor;
			end else begin
				dx = minor;
				dy = span;
			end
			xs = pick_start();
			ys = pick_start();
			xe = ($urandom_range(0, 1) != 0) ? xs + dx : xs - dx;
			ye = ($urandom_range(0, 1) != 0) ? ys + dy : ys - dy;
			// reflect back inside the range when the end falls off an edge
			if (xe < 0 || xe > COORD_TOP)
				xe = 2 * xs - xe;
			if (ye < 0 || ye > COORD_TOP)
				ye = 2 * ys - ye;
			c.kind    = mlr_pkg::KIND_LOAD;
			c.x_start = mlr_pkg::coord_t'(xs);
			c.y_start = mlr_pkg::coord_t'(ys);
			c.x_end   = mlr_pkg::coord_t'(xe);
			c.y_end   = mlr_pkg::coord_t'(ye);
			issue(c, 1'b0, none);
			steps = span;
			roll  = $urandom_range(0, 99);
			if (roll < 12)
				steps = $urandom_range(0, span);
			else if (roll < 24)
				steps = span + $urandom_range(1, 2);
			repeat (steps) issue(scrambled(mlr_pkg::KIND_ADVANCE), 1'b0, none);
		end
	endtask

	task automatic run_random(input int unsigned quota);
		int unsigned stop_at;
		stop_at = items_sent + quota;
		while (items_sent < stop_at)
			random_sequence();
	endtask

	task automatic add_row(input logic k, input int xs, input int ys, input int xe, input int ye,
			input logic typed, input pixel_t want);
		dir_row_t r;
		r.cmd   = '{k, mlr_pkg::coord_t'(xs), mlr_pkg::coord_t'(ys),
			mlr_pkg::coord_t'(xe), mlr_pkg::coord_t'(ye)};
		r.typed = typed;
		r.want  = want;
		directed_rows.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// hang detection
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end while (quiet < QUIET_LIMIT);
		$display("midpoint_line_rasterizer verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		pixel_t none;
		none = '0;

		// directed table, color still at its reset value
		// advance right after reset: nothing to draw
		add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b1, '0);
		// single point at the origin, done on its load
		add_row(mlr_pkg::KIND_LOAD, 0, 0, 0, 0, 1'b1,
			'{11'd0, 11'd0, 1'b1, 1'b1, mlr_pkg::COLOR_RESET});
		add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b1, '0);
		// single point at the far corner
		add_row(mlr_pkg::KIND_LOAD, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1'b1,
			'{mlr_pkg::coord_t'(COORD_TOP), mlr_pkg::coord_t'(COORD_TOP), 1'b1, 1'b1,
			mlr_pkg::COLOR_RESET});
		// flat line, walked to the end and one advance past it
		add_row(mlr_pkg::KIND_LOAD, 0, 5, 3, 5, 1'b0, none);
		repeat (3) add_row(mlr_pkg::KIND_ADVANCE, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP,
			1'b0, none);
		add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b1, '0);
		// shallow line given back to front, minor axis falling, ends on the edge
		add_row(mlr_pkg::KIND_LOAD, COORD_TOP, 0, COORD_TOP - 7, 2, 1'b0, none);
		repeat (2) add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b0, none);
		// reload mid-line: 45 degree line counts as steep
		add_row(mlr_pkg::KIND_LOAD, 0, 0, 3, 3, 1'b0, none);
		repeat (3) add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b0, none);
		// steep line with x falling
		add_row(mlr_pkg::KIND_LOAD, 5, 0, 2, 10, 1'b0, none);
		repeat (2) add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b0, none);
		// full-range diagonal, first pixel at the start corner, then dropped
		add_row(mlr_pkg::KIND_LOAD, COORD_TOP, 0, 0, COORD_TOP, 1'b1,
			'{mlr_pkg::coord_t'(COORD_TOP), 11'd0, 1'b1, 1'b0, mlr_pkg::COLOR_RESET});
		repeat (2) add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b0, none);
		// full-height vertical line given top down
		add_row(mlr_pkg::KIND_LOAD, 0, COORD_TOP, 0, 0, 1'b0, none);
		repeat (2) add_row(mlr_pkg::KIND_ADVANCE, 0, 0, 0, 0, 1'b0, none);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

		// random traffic under several colors, extremes first; each phase
		// pauses once mid-way until all pixels are back
		drain_pipeline();
		write_color('0);
		run_random(PHASE_ITEMS / 2);
		drain_pipeline();
		run_random(PHASE_ITEMS / 2);

		drain_pipeline();
		write_color('1);
		run_random(PHASE_ITEMS / 2);
		drain_pipeline();
		run_random(PHASE_ITEMS / 2);

		repeat (3) begin
			drain_pipeline();
			write_color(mlr_pkg::COLOR_BITS'($urandom_range(0, 255)));
			run_random(PHASE_ITEMS / 2);
			drain_pipeline();
			run_random(PHASE_ITEMS / 2);
		end

		// wait for the last pixels, then a little longer to catch strays
		drain_pipeline();
		repeat (4 * PIPE_LATENCY) @(posedge clk);

		if (fail_count == 0)
			$display("midpoint_line_rasterizer verification clean");
		else
			$display("midpoint_line_rasterizer verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/mlr_pkg.sv
rtl/mlr_front.sv
rtl/mlr_queue.sv
rtl/mlr_back.sv
rtl/midpoint_line_rasterizer.sv
tb/midpoint_line_rasterizer_tb.sv
